>>> design/agc_pkg.sv
// ----------------------------------------------------------------------------
// agc_pkg
// Shared types and constants of the anagram group classifier.
// ----------------------------------------------------------------------------
package agc_pkg;

    localparam int MAX_GROUPS  = 64;
    localparam int MAX_KEY_LEN = 64;
    localparam int GROUP_W     = $clog2(MAX_GROUPS);
    localparam int USED_W      = $clog2(MAX_GROUPS + 1);
    localparam int LEN_W       = $clog2(MAX_KEY_LEN + 2);
    localparam int POS_W       = $clog2(MAX_KEY_LEN);
    localparam int KEY_W       = 8 * MAX_KEY_LEN;
    localparam int COUNT_W     = 16;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } item_t;

    typedef struct packed {
        logic [5:0]  group_index;
        logic        new_group;
        logic [15:0] group_size;
        logic [1:0]  status;
    } result_t;

endpackage

>>> design/anagram_group_classifier_unit.sv
// ----------------------------------------------------------------------------
// anagram_group_classifier_unit
// Groups words that are anagrams of each other and reports each word's group.
// ----------------------------------------------------------------------------
// Words enter one byte per input transaction on item, with last_char set on
// the final byte. Bytes are sorted on arrival, so a byte is taken every cycle
// while a word is being received. After the last byte the group table is
// searched in creation order; each stored group costs one read of the table
// memories and one compare. A word therefore stalls the input after its last
// byte while its search runs, G groups being compared (at most 64), or none
// for a word that is too long or when the table is empty. One result
// transaction follows each word on result, from an output register, valid at
// the edge that ends the stall. If the receiver stalls, the finished result
// waits in the search unit and the input stays stalled until it can be
// handed over. Reset empties the group table and the partial word at once;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module anagram_group_classifier_unit
    import agc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic             accept;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] key_len;
    logic             busy;
    logic             done;
    result_t          res;
    logic             out_valid_reg;
    result_t          out_data_reg;

    assign item_stall = busy;
    assign accept     = item_valid && !busy;

    agc_sorter u_sorter (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .char_code (item.char_code),
        .clear     (done),
        .key       (key),
        .key_len   (key_len)
    );

    agc_search u_search (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && item.last_char),
        .key      (key),
        .key_len  (key_len),
        .out_busy (out_valid_reg && result_stall),
        .busy     (busy),
        .done     (done),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_data_reg <= res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

>>> design/agc_sorter.sv
// ----------------------------------------------------------------------------
// agc_sorter
// Insertion sorter: a row of byte cells kept in ascending order as bytes
// arrive, with a saturating word length counter.
// ----------------------------------------------------------------------------
module agc_sorter
    import agc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [7:0]       char_code,
    input  logic             clear,
    output logic [KEY_W-1:0] key,
    output logic [LEN_W-1:0] key_len
);

    logic [7:0]       cell_reg [MAX_KEY_LEN];
    logic [7:0]       cell_next [MAX_KEY_LEN];
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             gt [MAX_KEY_LEN];

    always_comb
    begin
        for (int i = 0; i < MAX_KEY_LEN; i++)
        begin
            gt[i] = (LEN_W'(i) >= len_reg) || (cell_reg[i] > char_code);
        end
        cell_next[0] = gt[0] ? char_code : cell_reg[0];
        for (int i = 1; i < MAX_KEY_LEN; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (gt[i])
            begin
                cell_next[i] = gt[i-1] ? cell_reg[i-1] : char_code;
            end
        end
        len_next = len_reg;
        if (clear)
        begin
            len_next = '0;
        end
        else if (push && (len_reg <= LEN_W'(MAX_KEY_LEN)))
        begin
            len_next = len_reg + LEN_W'(1);
        end
        for (int i = 0; i < MAX_KEY_LEN; i++)
        begin
            key[8*i +: 8] = (LEN_W'(i) < len_reg) ? cell_reg[i] : 8'd0;
        end
    end

    assign key_len = len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && (len_reg < LEN_W'(MAX_KEY_LEN)))
        begin
            for (int i = 0; i < MAX_KEY_LEN; i++)
            begin
                cell_reg[i] <= cell_next[i];
            end
        end
    end

endmodule

>>> design/agc_search.sv
// ----------------------------------------------------------------------------
// agc_search
// Group table held in two memories, one key row and one length and count
// entry per group, searched in creation order, one read and one compare per group.
// ----------------------------------------------------------------------------
module agc_search
    import agc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [KEY_W-1:0] key,
    input  logic [LEN_W-1:0] key_len,
    input  logic             out_busy,
    output logic             busy,
    output logic             done,
    output result_t          res
);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_CMP, S_DONE} state_t;

    localparam int INFO_W = LEN_W + COUNT_W;

    logic [KEY_W-1:0]  key_mem  [MAX_GROUPS];
    logic [INFO_W-1:0] info_mem [MAX_GROUPS];
    logic [KEY_W-1:0]  key_rd_reg;
    logic [INFO_W-1:0] info_rd_reg;

    state_t             state_reg;
    logic [GROUP_W-1:0] g_reg;
    logic [USED_W-1:0]  used_reg;
    logic               found_reg;
    logic               long_reg;

    logic               match;
    logic               last_group;
    logic [COUNT_W-1:0] count_inc;
    logic               finish;
    logic               upd_found;
    logic               upd_new;

    assign match      = (info_rd_reg[INFO_W-1 -: LEN_W] == key_len) && (key_rd_reg == key);
    assign last_group = (USED_W'({1'b0, g_reg}) + USED_W'(1)) == used_reg;
    assign count_inc  = (info_rd_reg[COUNT_W-1:0] == {COUNT_W{1'b1}}) ?
                        info_rd_reg[COUNT_W-1:0] : info_rd_reg[COUNT_W-1:0] + COUNT_W'(1);
    assign finish     = (state_reg == S_DONE) && !out_busy;
    assign upd_found  = finish && !long_reg && found_reg;
    assign upd_new    = finish && !long_reg && !found_reg &&
                        (used_reg != USED_W'(MAX_GROUPS));
    assign busy       = (state_reg != S_IDLE);
    assign done       = finish;

    always_comb
    begin
        res = '0;
        if (long_reg)
        begin
            res.status = STATUS_TOO_LONG;
        end
        else if (found_reg)
        begin
            res.group_index = 6'(g_reg);
            res.group_size  = count_inc;
        end
        else if (used_reg == USED_W'(MAX_GROUPS))
        begin
            res.status = STATUS_FULL;
        end
        else
        begin
            res.group_index = 6'(used_reg);
            res.new_group   = 1'b1;
            res.group_size  = COUNT_W'(1);
        end
    end

    // The start edge also stores the last byte, so key_len still lacks it here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            g_reg     <= '0;
            used_reg  <= '0;
            found_reg <= 1'b0;
            long_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        g_reg     <= '0;
                        found_reg <= 1'b0;
                        long_reg  <= (key_len >= LEN_W'(MAX_KEY_LEN));
                        if ((key_len >= LEN_W'(MAX_KEY_LEN)) || (used_reg == '0))
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (match)
                    begin
                        found_reg <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else if (last_group)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        g_reg     <= g_reg + GROUP_W'(1);
                        state_reg <= S_READ;
                    end
                end
                S_DONE:
                begin
                    if (!out_busy)
                    begin
                        if (upd_new)
                        begin
                            used_reg <= used_reg + USED_W'(1);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            key_rd_reg  <= key_mem[g_reg];
            info_rd_reg <= info_mem[g_reg];
        end
        if (upd_found)
        begin
            info_mem[g_reg] <= {key_len, count_inc};
        end
        if (upd_new)
        begin
            key_mem[GROUP_W'(used_reg)]  <= key;
            info_mem[GROUP_W'(used_reg)] <= {key_len, COUNT_W'(1)};
        end
    end

endmodule

>>> tb/anagram_group_classifier_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anagram_group_classifier_unit_checker
// Watches both channels, predicts each word's group and compares results.
// ----------------------------------------------------------------------------
module anagram_group_classifier_unit_checker
    import agc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_stall,
    input  item_t   item,
    input  logic    result_valid,
    input  logic    result_stall,
    input  result_t result,
    output int      fail_count,
    output int      pending_words
);

    logic [7:0]  word_bytes [MAX_KEY_LEN];
    int          word_len;
    logic [7:0]  group_keys [MAX_GROUPS][MAX_KEY_LEN];
    int          group_key_len [MAX_GROUPS];
    int          group_members [MAX_GROUPS];
    int          group_count;
    result_t     expected_results [$];

    initial fail_count = 0;
    assign pending_words = expected_results.size();

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    function automatic result_t classify_byte(input item_t it, output bit produced);
        logic [7:0] key [MAX_KEY_LEN];
        logic [7:0] v;
        int len;
        int j;
        int g;
        bit found;
        bit same;
        result_t r;
        r = '0;
        produced = 0;
        if (word_len < MAX_KEY_LEN)
            word_bytes[word_len] = it.char_code;
        if (word_len <= MAX_KEY_LEN)
            word_len++;
        if (!it.last_char)
            return r;
        produced = 1;
        len = word_len;
        word_len = 0;
        if (len > MAX_KEY_LEN)
        begin
            r.status = STATUS_TOO_LONG;
            return r;
        end
        for (int i = 0; i < len; i++)
            key[i] = word_bytes[i];
        for (int i = 1; i < len; i++)
        begin
            v = key[i];
            j = i;
            while (j > 0 && key[j - 1] > v)
            begin
                key[j] = key[j - 1];
                j--;
            end
            key[j] = v;
        end
        found = 0;
        for (g = 0; g < group_count; g++)
        begin
            same = (group_key_len[g] == len);
            for (int i = 0; same && i < len; i++)
                if (group_keys[g][i] != key[i])
                    same = 0;
            if (same)
            begin
                found = 1;
                break;
            end
        end
        if (found)
        begin
            if (group_members[g] < 65535)
                group_members[g]++;
            r.group_index = g[5:0];
            r.group_size = group_members[g][15:0];
        end
        else if (group_count >= MAX_GROUPS)
            r.status = STATUS_FULL;
        else
        begin
            g = group_count;
            for (int i = 0; i < len; i++)
                group_keys[g][i] = key[i];
            group_key_len[g] = len;
            group_members[g] = 1;
            group_count++;
            r.group_index = g[5:0];
            r.group_size = 16'd1;
            r.new_group = 1'b1;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t r;
        result_t w;
        bit produced;
        if (!rst_n)
        begin
            word_len = 0;
            group_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                r = classify_byte(item, produced);
                if (produced)
                    expected_results.push_back(r);
            end
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result transaction", 1, 0);
                else
                begin
                    w = expected_results.pop_front();
                    if (result.group_index !== w.group_index)
                        report_mismatch("group_index", result.group_index, w.group_index);
                    if (result.new_group !== w.new_group)
                        report_mismatch("new_group", result.new_group, w.new_group);
                    if (result.group_size !== w.group_size)
                        report_mismatch("group_size", result.group_size, w.group_size);
                    if (result.status !== w.status)
                        report_mismatch("status", result.status, w.status);
                end
            end
        end
    end

endmodule

>>> tb/anagram_group_classifier_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anagram_group_classifier_unit_tb
// Drives words through the anagram group classifier and gives the verdict.
// ----------------------------------------------------------------------------
// Directed words cover extreme bytes, zero and all-ones, anagram repeats,
// overlong words and the maximum length. Random words then fill the group
// table to overflow, while the sender and receiver idle at random.
// ----------------------------------------------------------------------------
module anagram_group_classifier_unit_tb;
    import agc_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;
    int      fail_count;
    int      pending_words;
    int      idle_cycles;
    int      bytes_sent;
    bit      hold_off;
    logic [7:0] pool [8][8];

    anagram_group_classifier_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    anagram_group_classifier_unit_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .item          (item),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // The sender drives one byte and waits for its transaction.
    task automatic send_byte(input logic [7:0] b, input logic last);
        item_valid <= 1'b1;
        item <= '{char_code: b, last_char: last};
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        bytes_sent++;
        if ($urandom_range(0, 7) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic send_word(input logic [7:0] w [], input int len);
        for (int i = 0; i < len; i++)
            send_byte(w[i], i == len - 1);
    endtask

    task automatic send_shuffled(input int p, input int len);
        logic [7:0] w [];
        logic [7:0] t;
        int k;
        w = new[len];
        for (int i = 0; i < len; i++)
            w[i] = pool[p][i];
        for (int i = len - 1; i > 0; i--)
        begin
            k = $urandom_range(0, i);
            t = w[i];
            w[i] = w[k];
            w[k] = t;
        end
        send_word(w, len);
    endtask

    task automatic send_random(input int len);
        logic [7:0] w [];
        w = new[len];
        for (int i = 0; i < len; i++)
            w[i] = $urandom_range(0, 255);
        send_word(w, len);
    endtask

    task automatic send_fill(input logic [7:0] b, input int len);
        logic [7:0] w [];
        w = new[len];
        for (int i = 0; i < len; i++)
            w[i] = b;
        send_word(w, len);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else if (hold_off)
            result_stall <= 1'b1;
        else
            result_stall <= ($urandom_range(0, 99) < 30) && ((bytes_sent & 256) != 0);
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("anagram_group_classifier_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        hold_off = 0;
        wait (bytes_sent > 700);
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
    end

    initial
    begin
        logic [7:0] w [];
        int p;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        idle_cycles = 0;
        bytes_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        w = new[3];
        w = '{8'h00, 8'hFF, 8'h01};
        send_word(w, 3);
        w = '{8'hFF, 8'h01, 8'h00};
        send_word(w, 3);
        send_fill(8'hFF, 1);
        send_fill(8'h00, 1);
        send_fill(8'h55, 64);
        send_fill(8'hAA, 65);
        send_fill(8'h55, 64);
        send_fill(8'h5A, 70);
        send_fill(8'h01, 2);

        item_valid <= 1'b0;
        wait (pending_words == 0);
        repeat (5) @(posedge clk);

        for (int i = 0; i < 8; i++)
            for (int j = 0; j < 8; j++)
                pool[i][j] = $urandom_range(0, 255);

        while (bytes_sent < 1900)
        begin
            p = $urandom_range(0, 9);
            if (p < 6)
                send_shuffled(p, $urandom_range(1, 8) > 4 ? 8 : 4);
            else if (p < 9)
                send_random($urandom_range(1, 6));
            else
                send_random($urandom_range(60, 67));
            if ($urandom_range(0, 3) == 0)
            begin
                item_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        item_valid <= 1'b0;
        wait (pending_words == 0);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("anagram_group_classifier_unit regression: pass");
        else
            $display("anagram_group_classifier_unit regression: fail");
        $finish;
    end

endmodule
